### hdl/bqt_pkg.sv
package bqt_pkg;

    // Field and datapath widths
    localparam int SIZE_W   = 31;                 // unsigned box sizes and steps
    localparam int HALF_W   = SIZE_W - 1;         // size >> 1
    localparam int COORD_W  = 32;                 // signed vertex coordinates
    localparam int GRID_W   = 8;                  // grid division count
    localparam int IDX_W    = 8;                  // row / column index
    localparam int FACE_W   = 3;                  // face select
    localparam int PROD_W   = SIZE_W + IDX_W + 1; // (index + 1) * step
    localparam int WIDE_W   = PROD_W + 2;         // signed edge before saturation
    localparam int VIDX_W   = 3;                  // vertex counter within a cell

    // APB register file
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Defaults for top-level parameters
    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_MAX_DIVISIONS = 255;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BOX_LENGTH = 2'd2;
    localparam logic [1:0] REG_GRID_DIVS  = 2'd3;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd5;

    // Last vertex of a cell
    localparam logic [VIDX_W-1:0] VERT_LAST = 3'd5;

    // Face pairs sharing an axis layout
    typedef enum logic [1:0] {
        GRP_FRONT_BACK,
        GRP_TOP_BOTTOM,
        GRP_RIGHT_LEFT
    } face_grp_t;

    // Three box dimensions (sizes or steps)
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [SIZE_W-1:0] length;
    } box_dims_t;

    // One classified cell, ready for vertex emission
    typedef struct packed {
        face_grp_t                   grp;
        logic                        rev;
        logic signed [COORD_W-1:0]   a0;
        logic signed [COORD_W-1:0]   a1;
        logic signed [COORD_W-1:0]   b0;
        logic signed [COORD_W-1:0]   b1;
        logic signed [COORD_W-1:0]   fixed_c;
    } edge_entry_t;

    // Clamp a wide edge value to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] cmax;
        logic signed [WIDE_W-1:0] cmin;
        cmax = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        cmin = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > cmax)
            return cmax[COORD_W-1:0];
        else if (v < cmin)
            return cmin[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

    // Corner slot used by each of the six vertices (v1 v2 v3 v1 v3 v6)
    function automatic logic [1:0] slot_corner(input logic [VIDX_W-1:0] k);
        logic [1:0] c;
        case (k)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

### hdl/bqt_step_div.sv
module bqt_step_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  bqt_pkg::box_dims_t         sizes,
    input  logic [bqt_pkg::GRID_W-1:0] divs,
    output bqt_pkg::box_dims_t         steps,
    output logic                       busy
);
    import bqt_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W + 1);
    localparam logic [SIZE_W-1:0] RESET_STEP = SIZE_W'(64'd1 << FRAC_BITS);

    box_dims_t         quo_reg;
    box_dims_t         quo_next;
    logic [GRID_W-1:0] rem_w_reg, rem_h_reg, rem_l_reg;
    logic [GRID_W-1:0] rem_w_next, rem_h_next, rem_l_next;
    logic [GRID_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              qb_w, qb_h, qb_l;

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [GRID_W:0] div_step(
        input logic [GRID_W-1:0] rem,
        input logic              dbit,
        input logic [GRID_W-1:0] d
    );
        logic [GRID_W:0] trial;
        logic [GRID_W:0] diff;
        trial = {rem, dbit};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
            return {diff[GRID_W-1:0], 1'b1};
        else
            return {trial[GRID_W-1:0], 1'b0};
    endfunction

    // Three quotients, one bit each per cycle
    always_comb
    begin
        {rem_w_next, qb_w} = div_step(rem_w_reg, quo_reg.width[SIZE_W-1], div_reg);
        {rem_h_next, qb_h} = div_step(rem_h_reg, quo_reg.height[SIZE_W-1], div_reg);
        {rem_l_next, qb_l} = div_step(rem_l_reg, quo_reg.length[SIZE_W-1], div_reg);
        quo_next.width  = {quo_reg.width[SIZE_W-2:0], qb_w};
        quo_next.height = {quo_reg.height[SIZE_W-2:0], qb_h};
        quo_next.length = {quo_reg.length[SIZE_W-2:0], qb_l};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '{width: RESET_STEP, height: RESET_STEP, length: RESET_STEP};
            rem_w_reg <= '0;
            rem_h_reg <= '0;
            rem_l_reg <= '0;
            div_reg   <= GRID_W'(1);
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else if (start)
        begin
            quo_reg   <= sizes;
            rem_w_reg <= '0;
            rem_h_reg <= '0;
            rem_l_reg <= '0;
            div_reg   <= divs;
            cnt_reg   <= '0;
            busy_reg  <= 1'b1;
        end
        else if (busy_reg)
        begin
            quo_reg   <= quo_next;
            rem_w_reg <= rem_w_next;
            rem_h_reg <= rem_h_next;
            rem_l_reg <= rem_l_next;
            cnt_reg   <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SIZE_W - 1))
                busy_reg <= 1'b0;
        end
    end

    assign steps = quo_reg;
    assign busy  = busy_reg | start;

endmodule

### hdl/bqt_front.sv
module bqt_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [bqt_pkg::FACE_W-1:0] face_select,
    input  logic [bqt_pkg::IDX_W-1:0]  cell_row,
    input  logic [bqt_pkg::IDX_W-1:0]  cell_col,
    input  bqt_pkg::box_dims_t         sizes,
    input  bqt_pkg::box_dims_t         steps,
    input  logic                       div_busy,
    input  logic                       q_pop,
    output logic                       q_push,
    output bqt_pkg::edge_entry_t       q_entry
);
    import bqt_pkg::*;

    localparam int CRD_W = $clog2(QUEUE_DEPTH + 1);

    logic [CRD_W-1:0]       credit_reg;
    logic [CRD_W-1:0]       credit_next;
    logic                   take;
    logic                   keep;

    face_grp_t              grp_sel;
    logic [SIZE_W-1:0]      step_a, step_b, size_a, size_b, size_c;
    logic [IDX_W:0]         row_hi, col_hi;

    logic                   s1_valid_reg;
    face_grp_t              s1_grp_reg;
    logic                   s1_rev_reg;
    logic [PROD_W-1:0]      s1_pa0_reg, s1_pa1_reg, s1_pb0_reg, s1_pb1_reg;
    logic [HALF_W-1:0]      s1_half_a_reg, s1_half_b_reg;
    logic signed [COORD_W-1:0] s1_fixed_reg;
    logic signed [COORD_W-1:0] fixed_next;

    // Request acceptance; unknown faces are taken and dropped
    assign full = div_busy || (credit_reg >= CRD_W'(QUEUE_DEPTH));
    assign take = push && !full;
    assign keep = take && (face_select <= FACE_LEFT);

    // Slots held by the stage register plus the queue
    always_comb
    begin
        credit_next = credit_reg;
        if (keep && !q_pop)
            credit_next = credit_reg + 1'b1;
        else if (!keep && q_pop)
            credit_next = credit_reg - 1'b1;
    end

    // Axis selection per face pair
    always_comb
    begin
        case (face_select)
            FACE_FRONT, FACE_BACK:
            begin
                grp_sel = GRP_FRONT_BACK;
                size_a  = sizes.height;  step_a = steps.height;
                size_b  = sizes.width;   step_b = steps.width;
                size_c  = sizes.length;
            end
            FACE_TOP, FACE_BOTTOM:
            begin
                grp_sel = GRP_TOP_BOTTOM;
                size_a  = sizes.width;   step_a = steps.width;
                size_b  = sizes.length;  step_b = steps.length;
                size_c  = sizes.height;
            end
            default:
            begin
                grp_sel = GRP_RIGHT_LEFT;
                size_a  = sizes.height;  step_a = steps.height;
                size_b  = sizes.length;  step_b = steps.length;
                size_c  = sizes.width;
            end
        endcase
        row_hi = {1'b0, cell_row} + 1'b1;
        col_hi = {1'b0, cell_col} + 1'b1;
        fixed_next = $signed(COORD_W'(size_c[SIZE_W-1:1]));
        if (face_select[0])
            fixed_next = -fixed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= keep;
        end
    end

    // Stage 1: edge products
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            s1_grp_reg    <= grp_sel;
            s1_rev_reg    <= face_select[0];
            s1_pa0_reg    <= PROD_W'({1'b0, cell_row}) * PROD_W'(step_a);
            s1_pa1_reg    <= PROD_W'(row_hi) * PROD_W'(step_a);
            s1_pb0_reg    <= PROD_W'({1'b0, cell_col}) * PROD_W'(step_b);
            s1_pb1_reg    <= PROD_W'(col_hi) * PROD_W'(step_b);
            s1_half_a_reg <= size_a[SIZE_W-1:1];
            s1_half_b_reg <= size_b[SIZE_W-1:1];
            s1_fixed_reg  <= fixed_next;
        end
    end

    // Stage 2: offset by the half size and saturate, into the queue
    always_comb
    begin
        q_entry.grp     = s1_grp_reg;
        q_entry.rev     = s1_rev_reg;
        q_entry.a0      = sat_coord($signed(WIDE_W'(s1_pa0_reg)) -
                                    $signed(WIDE_W'(s1_half_a_reg)));
        q_entry.a1      = sat_coord($signed(WIDE_W'(s1_pa1_reg)) -
                                    $signed(WIDE_W'(s1_half_a_reg)));
        q_entry.b0      = sat_coord($signed(WIDE_W'(s1_pb0_reg)) -
                                    $signed(WIDE_W'(s1_half_b_reg)));
        q_entry.b1      = sat_coord($signed(WIDE_W'(s1_pb1_reg)) -
                                    $signed(WIDE_W'(s1_half_b_reg)));
        q_entry.fixed_c = s1_fixed_reg;
    end

    assign q_push = s1_valid_reg;

endmodule

### hdl/bqt_queue.sv
module bqt_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  bqt_pkg::edge_entry_t  wr_data,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output bqt_pkg::edge_entry_t  rd_data
);
    import bqt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    edge_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (!wr_en && rd_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

endmodule

### hdl/bqt_back.sv
module bqt_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  bqt_pkg::edge_entry_t               q_entry,
    output logic                               q_pop,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_x,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_y,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_z,
    output logic                               last_vertex
);
    import bqt_pkg::*;

    edge_entry_t        cur_reg;
    logic               cur_valid_reg;
    logic [VIDX_W-1:0]  vidx_reg;
    logic               at_last;
    logic               load;
    logic [VIDX_W-1:0]  src;
    logic [1:0]         corner;
    logic               sel_a, sel_b;
    logic signed [COORD_W-1:0] coord_a, coord_b;

    assign at_last = (vidx_reg == VERT_LAST);
    assign load    = q_valid && (!cur_valid_reg || (pop && at_last));
    assign q_pop   = load;

    // Vertex sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            vidx_reg      <= '0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
            vidx_reg      <= '0;
        end
        else if (pop && cur_valid_reg)
        begin
            if (at_last)
                cur_valid_reg <= 1'b0;
            vidx_reg <= vidx_reg + 1'b1;
        end
    end

    // Current cell
    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_entry;
    end

    // Corner pick: reversed faces walk the six slots backwards
    always_comb
    begin
        src    = cur_reg.rev ? (VERT_LAST - vidx_reg) : vidx_reg;
        corner = slot_corner(src);
        sel_a  = corner[1];
        sel_b  = corner[1] ^ corner[0];
        if (cur_reg.grp == GRP_RIGHT_LEFT)
            sel_b = ~sel_b;
        coord_a = sel_a ? cur_reg.a1 : cur_reg.a0;
        coord_b = sel_b ? cur_reg.b1 : cur_reg.b0;
    end

    // Axis placement
    always_comb
    begin
        case (cur_reg.grp)
            GRP_FRONT_BACK:
            begin
                vert_x = coord_b;
                vert_y = coord_a;
                vert_z = cur_reg.fixed_c;
            end
            GRP_TOP_BOTTOM:
            begin
                vert_x = coord_a;
                vert_y = cur_reg.fixed_c;
                vert_z = coord_b;
            end
            GRP_RIGHT_LEFT:
            begin
                vert_x = cur_reg.fixed_c;
                vert_y = coord_a;
                vert_z = coord_b;
            end
            default:
            begin
                vert_x = coord_b;
                vert_y = coord_a;
                vert_z = cur_reg.fixed_c;
            end
        endcase
    end

    assign empty       = !cur_valid_reg;
    assign last_vertex = at_last;

endmodule

### hdl/box_quad_tessellator.sv
// Box grid-cell vertex generator.
// Configure the box through the APB port: width, height and length (unsigned
// fixed point, 31 bits) and the grid division count (0 behaves as 1). Requests
// enter by push/full: one request names a face, a row and a column. Results
// leave by empty/pop: six vertices per cell in signed fixed point, the sixth
// flagged by last_vertex. Back, bottom and left faces come out in reverse order.
// Unknown faces (6, 7) are taken and produce nothing.
// The first vertex shows once a request taken into an idle block has passed
// the edge stage register, the queue and the current-cell register. The
// single result port emits one vertex per cycle while pop is high; a four-deep
// queue between the edge pipeline and the vertex sequencer absorbs bursts.
// Each register write restarts the step divider, a bit-serial unit over the
// three sizes; full stays high while the divider runs after the write.
// Reset restores unit sizes and one division, with steps ready at once.
// If pop is held low, the current vertex holds, the queue fills and full rises;
// nothing is lost.
module box_quad_tessellator #(
    parameter int FRAC_BITS     = bqt_pkg::DEF_FRAC_BITS,
    parameter int MAX_DIVISIONS = bqt_pkg::DEF_MAX_DIVISIONS,
    parameter int QUEUE_DEPTH   = bqt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bqt_pkg::ADDR_W-1:0]         paddr,
    input  logic [bqt_pkg::DATA_W-1:0]         pwdata,
    output logic [bqt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [bqt_pkg::FACE_W-1:0]         face_select,
    input  logic [bqt_pkg::IDX_W-1:0]          cell_row,
    input  logic [bqt_pkg::IDX_W-1:0]          cell_col,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_x,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_y,
    output logic signed [bqt_pkg::COORD_W-1:0] vert_z,
    output logic                               last_vertex
);
    import bqt_pkg::*;

    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(64'd1 << FRAC_BITS);

    box_dims_t          sizes_reg;
    logic [GRID_W-1:0]  grid_reg;
    logic               start_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic [GRID_W-1:0]  divs_eff;
    box_dims_t          steps;
    logic               div_busy;
    logic               q_push, q_valid, q_pop;
    edge_entry_t        q_wr_data, q_rd_data;

    // Register writes
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg <= '{width: RESET_SIZE, height: RESET_SIZE, length: RESET_SIZE};
            grid_reg  <= GRID_W'(1);
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_wr;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_BOX_WIDTH:  sizes_reg.width  <= pwdata[SIZE_W-1:0];
                    REG_BOX_HEIGHT: sizes_reg.height <= pwdata[SIZE_W-1:0];
                    REG_BOX_LENGTH: sizes_reg.length <= pwdata[SIZE_W-1:0];
                    REG_GRID_DIVS:  grid_reg         <= pwdata[GRID_W-1:0];
                    default:        grid_reg         <= grid_reg;
                endcase
            end
        end
    end

    // Register reads
    always_comb
    begin
        case (cfg_idx)
            REG_BOX_WIDTH:  prdata = DATA_W'(sizes_reg.width);
            REG_BOX_HEIGHT: prdata = DATA_W'(sizes_reg.height);
            REG_BOX_LENGTH: prdata = DATA_W'(sizes_reg.length);
            REG_GRID_DIVS:  prdata = DATA_W'(grid_reg);
            default:        prdata = '0;
        endcase
    end

    // Effective division count: zero as one, clamp to the maximum
    always_comb
    begin
        if (grid_reg == '0)
            divs_eff = GRID_W'(1);
        else if (32'(grid_reg) > MAX_DIVISIONS)
            divs_eff = GRID_W'(MAX_DIVISIONS);
        else
            divs_eff = grid_reg;
    end

    bqt_step_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .sizes (sizes_reg),
        .divs  (divs_eff),
        .steps (steps),
        .busy  (div_busy)
    );

    bqt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .face_select (face_select),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .sizes       (sizes_reg),
        .steps       (steps),
        .div_busy    (div_busy),
        .q_pop       (q_pop),
        .q_push      (q_push),
        .q_entry     (q_wr_data)
    );

    bqt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_data),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    bqt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .last_vertex (last_vertex)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bqt_pkg::*;

    // Face codes the block drops without output
    localparam logic [FACE_W-1:0] FACE_UNUSED_6 = 3'd6;
    localparam logic [FACE_W-1:0] FACE_UNUSED_7 = 3'd7;

    // Unit box half size in Q16.16
    localparam int HALF_UNIT = 32768;

    // Corner slot per emitted vertex v1 v2 v3 v1 v3 v6, two bits each, vertex 0 lowest
    localparam logic [11:0] VERT_SLOTS = {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    localparam int DIR_ROWS       = 16;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_REQS     = 75;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } vertex_t;

    // Directed request; first emitted vertex typed in where marked
    typedef struct {
        logic [FACE_W-1:0] face;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        bit                typed;
        int                tx;
        int                ty;
        int                tz;
    } dir_req_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      push;
    logic                      full;
    logic [FACE_W-1:0]         face_select;
    logic [IDX_W-1:0]          cell_row;
    logic [IDX_W-1:0]          cell_col;
    logic                      empty;
    logic                      pop;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
    logic                      last_vertex;

    // Box settings as the block should hold them
    logic [SIZE_W-1:0] box_w;
    logic [SIZE_W-1:0] box_h;
    logic [SIZE_W-1:0] box_l;
    logic [GRID_W-1:0] divs;

    vertex_t pending_verts[$];

    int  fails;
    int  cells_sent;
    int  faces_dropped;
    int  verts_seen;
    int  settings_used;
    bit  gaps_on;
    bit  hold_req;

    dir_req_t dir_tab [DIR_ROWS] = '{
        '{FACE_FRONT,    8'd0,   8'd0,   1'b1, -HALF_UNIT, -HALF_UNIT,  HALF_UNIT},
        '{FACE_BACK,     8'd0,   8'd0,   1'b1, -HALF_UNIT,  HALF_UNIT, -HALF_UNIT},
        '{FACE_TOP,      8'd0,   8'd0,   1'b1, -HALF_UNIT,  HALF_UNIT, -HALF_UNIT},
        '{FACE_BOTTOM,   8'd0,   8'd0,   1'b1,  HALF_UNIT, -HALF_UNIT, -HALF_UNIT},
        '{FACE_RIGHT,    8'd0,   8'd0,   1'b1,  HALF_UNIT, -HALF_UNIT,  HALF_UNIT},
        '{FACE_LEFT,     8'd0,   8'd0,   1'b1, -HALF_UNIT,  HALF_UNIT,  HALF_UNIT},
        '{FACE_UNUSED_6, 8'd3,   8'd4,   1'b0, 0, 0, 0},
        '{FACE_UNUSED_7, 8'd254, 8'd254, 1'b0, 0, 0, 0},
        '{FACE_FRONT,    8'd254, 8'd254, 1'b0, 0, 0, 0},
        '{FACE_BACK,     8'd254, 8'd0,   1'b0, 0, 0, 0},
        '{FACE_TOP,      8'd0,   8'd254, 1'b0, 0, 0, 0},
        '{FACE_BOTTOM,   8'd254, 8'd254, 1'b0, 0, 0, 0},
        '{FACE_RIGHT,    8'd1,   8'd254, 1'b0, 0, 0, 0},
        '{FACE_LEFT,     8'd254, 8'd1,   1'b0, 0, 0, 0},
        '{FACE_FRONT,    8'd170, 8'd85,  1'b0, 0, 0, 0},
        '{FACE_TOP,      8'd85,  8'd170, 1'b0, 0, 0, 0}
    };

    box_quad_tessellator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .face_select (face_select),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .empty       (empty),
        .pop         (pop),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .last_vertex (last_vertex)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Grid line k (or k+1) along one axis, clamped to the coordinate range
    function automatic logic signed [COORD_W-1:0] grid_edge(
        input logic [SIZE_W-1:0] size,
        input int unsigned       n,
        input logic [IDX_W-1:0]  k,
        input int                hi
    );
        longint half;
        longint step;
        longint v;
        half = longint'(size >> 1);
        step = longint'(size) / longint'(n);
        v = (longint'(k) + longint'(hi)) * step - half;
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    // Six vertices of one grid cell, appended in emission order
    function automatic void tessellate_cell(
        input logic [FACE_W-1:0] face,
        input logic [IDX_W-1:0]  row,
        input logic [IDX_W-1:0]  col
    );
        int unsigned               n;
        face_grp_t                 grp;
        logic [SIZE_W-1:0]         size_a;
        logic [SIZE_W-1:0]         size_b;
        logic [SIZE_W-1:0]         size_c;
        logic signed [COORD_W-1:0] a0, a1, b0, b1, fixc, va, vb;
        logic [1:0]                slot;
        bit                        rev;
        bit                        bsel;
        vertex_t                   corner_verts [6];
        vertex_t                   vtx;
        if (face > FACE_LEFT)
            return;
        n = (divs == 0) ? 1 : divs;
        rev = face[0];
        if (face < FACE_TOP)
        begin
            grp = GRP_FRONT_BACK;
            size_a = box_h; size_b = box_w; size_c = box_l;
        end
        else if (face < FACE_RIGHT)
        begin
            grp = GRP_TOP_BOTTOM;
            size_a = box_w; size_b = box_l; size_c = box_h;
        end
        else
        begin
            grp = GRP_RIGHT_LEFT;
            size_a = box_h; size_b = box_l; size_c = box_w;
        end
        a0 = grid_edge(size_a, n, row, 0);
        a1 = grid_edge(size_a, n, row, 1);
        b0 = grid_edge(size_b, n, col, 0);
        b1 = grid_edge(size_b, n, col, 1);
        fixc = COORD_W'(size_c >> 1);
        if (rev)
            fixc = -fixc;

        // corner picks per vertex; right/left runs the b axis the other way
        for (int k = 0; k < 6; k++)
        begin
            slot = VERT_SLOTS[2*k +: 2];
            if (grp == GRP_RIGHT_LEFT)
                bsel = (slot == 2'd0) || (slot == 2'd3);
            else
                bsel = (slot == 2'd1) || (slot == 2'd2);
            va = slot[1] ? a1 : a0;
            vb = bsel ? b1 : b0;
            case (grp)
                GRP_FRONT_BACK:
                begin
                    vtx.x = vb;   vtx.y = va;   vtx.z = fixc;
                end
                GRP_TOP_BOTTOM:
                begin
                    vtx.x = va;   vtx.y = fixc; vtx.z = vb;
                end
                default:
                begin
                    vtx.x = fixc; vtx.y = va;   vtx.z = vb;
                end
            endcase
            vtx.last = 1'b0;
            corner_verts[k] = vtx;
        end

        // back, bottom and left come out reversed
        for (int k = 0; k < 6; k++)
        begin
            vtx = corner_verts[rev ? 5 - k : k];
            vtx.last = (k == 5);
            pending_verts.insert(pending_verts.size(), vtx);
        end
    endfunction

    // One register write over APB, entered and left at a falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_BOX_WIDTH:  box_w = data[SIZE_W-1:0];
            REG_BOX_HEIGHT: box_h = data[SIZE_W-1:0];
            REG_BOX_LENGTH: box_l = data[SIZE_W-1:0];
            default:        divs  = data[GRID_W-1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_box(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                           input logic [DATA_W-1:0] l, input logic [DATA_W-1:0] n);
        write_reg(REG_BOX_WIDTH, w);
        write_reg(REG_BOX_HEIGHT, h);
        write_reg(REG_BOX_LENGTH, l);
        write_reg(REG_GRID_DIVS, n);
        settings_used++;
    endtask

    // Offer one cell request; returns at the falling edge after it is taken
    task automatic send_cell(input logic [FACE_W-1:0] face, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input bit typed,
                             input int tx, input int ty, input int tz);
        int idx;
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        push        <= 1'b1;
        face_select <= face;
        cell_row    <= row;
        cell_col    <= col;
        do
            @(posedge clk);
        while (full);
        tessellate_cell(face, row, col);
        if (face > FACE_LEFT)
            faces_dropped++;
        else if (typed)
        begin
            idx = pending_verts.size() - 6;
            pending_verts[idx].x = tx;
            pending_verts[idx].y = ty;
            pending_verts[idx].z = tz;
        end
        cells_sent++;
        @(negedge clk);
    endtask

    // Random request: mostly inside the grid, some anywhere, a few unknown faces
    task automatic send_random_cell();
        int unsigned       n;
        logic [FACE_W-1:0] face;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        n = (divs == 0) ? 1 : divs;
        if ($urandom_range(0, 99) < 8)
            face = FACE_W'(FACE_UNUSED_6 + $urandom_range(0, 1));
        else
            face = FACE_W'($urandom_range(FACE_FRONT, FACE_LEFT));
        if ($urandom_range(0, 3) != 0)
        begin
            row = IDX_W'($urandom_range(0, n - 1));
            col = IDX_W'($urandom_range(0, n - 1));
        end
        else
        begin
            row = IDX_W'($urandom_range(0, 254));
            col = IDX_W'($urandom_range(0, 254));
        end
        send_cell(face, row, col, 1'b0, 0, 0, 0);
    endtask

    // Wait for every vertex, then let dropped requests clear the pipeline
    task automatic drain_block();
        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random pop gaps and one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (gaps_on && $urandom_range(0, 99) < 10)
                pop <= 1'b0;
            else
                pop <= 1'b1;
        end
    end

    // Vertex checker
    always @(posedge clk)
    begin
        vertex_t exp_v;
        if (rst_n && pop && !empty)
        begin
            verts_seen++;
            if (pending_verts.size() == 0)
            begin
                $error("vertex with no request pending: x=%0d y=%0d z=%0d",
                       vert_x, vert_y, vert_z);
                fails++;
            end
            else
            begin
                exp_v = pending_verts.pop_front();
                if (vert_x !== exp_v.x)
                begin
                    $error("vert_x: expected %0d, got %0d", exp_v.x, vert_x);
                    fails++;
                end
                if (vert_y !== exp_v.y)
                begin
                    $error("vert_y: expected %0d, got %0d", exp_v.y, vert_y);
                    fails++;
                end
                if (vert_z !== exp_v.z)
                begin
                    $error("vert_z: expected %0d, got %0d", exp_v.z, vert_z);
                    fails++;
                end
                if (last_vertex !== exp_v.last)
                begin
                    $error("last_vertex: expected %0b, got %0b", exp_v.last, last_vertex);
                    fails++;
                end
            end
        end
    end

    // Watchdog: too long without a request or vertex moving
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $error("no progress for %0d cycles, %0d vertices outstanding",
               WATCHDOG_LIMIT, pending_verts.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        push        = 1'b0;
        face_select = FACE_FRONT;
        cell_row    = '0;
        cell_col    = '0;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        fails       = 0;
        cells_sent  = 0;
        faces_dropped = 0;
        verts_seen  = 0;
        settings_used = 1;
        box_w = SIZE_W'(1 << DEF_FRAC_BITS);
        box_h = SIZE_W'(1 << DEF_FRAC_BITS);
        box_l = SIZE_W'(1 << DEF_FRAC_BITS);
        divs  = GRID_W'(1);

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed requests on the unit box
        for (int r = 0; r < DIR_ROWS; r++)
            send_cell(dir_tab[r].face, dir_tab[r].row, dir_tab[r].col, dir_tab[r].typed,
                      dir_tab[r].tx, dir_tab[r].ty, dir_tab[r].tz);

        // random phases, each on its own box setting
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            push <= 1'b0;
            drain_block();
            case (ph)
                0: set_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
                1: set_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
                2: set_box($urandom, $urandom, $urandom, $urandom_range(1, 8));
                3: set_box($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                           $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 255));
                4: set_box($urandom, $urandom, $urandom, $urandom);
                default: set_box($urandom, $urandom, $urandom, 32'h0000_0001);
            endcase
            gaps_on = (ph != 3);
            for (int i = 0; i < PHASE_REQS; i++)
            begin
                // stall the result side while requests keep coming
                if (ph == 2 && i == 10)
                    hold_req = 1'b1;
                send_random_cell();
            end
        end
        push <= 1'b0;

        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d cell requests (%0d on unknown faces) over %0d box settings,",
                 cells_sent, faces_dropped, settings_used);
        $display("%0d vertices checked, incl. saturated, zero-size and zero-division boxes",
                 verts_seen);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
